// ===== rtl/ufmt_pkg.sv =====
// ----------------------------------------------------------------------------
// ufmt_pkg - shared types and constants of the unsigned integer text formatter
// Holds format codes, ASCII constants, the job descriptor passed from the
// front end to the character emitter, and the digit-to-ASCII lookup.
// ----------------------------------------------------------------------------
package ufmt_pkg;

   localparam int DigitCount = 10;     // decimal digits of a 32-bit value
   localparam int FieldBits  = 7;      // width and precision fields
   localparam int DigitBits  = 4;      // digit count 0..10

   localparam logic [1:0] MODE_DEC  = 2'd0;
   localparam logic [1:0] MODE_LHEX = 2'd1;
   localparam logic [1:0] MODE_UHEX = 2'd2;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   typedef logic [DigitCount-1:0][3:0] digit_vec_type;

   // One formatting job: digits plus the run lengths of each text section.
   typedef struct packed {
      digit_vec_type        digits;    // nibble 0 is the least significant
      logic [DigitBits-1:0] ndig;      // digits to print
      logic [FieldBits-1:0] lead;      // precision zeros before the digits
      logic [FieldBits-1:0] pad;       // width fill characters
      logic                 fill_zero; // right-justified fill is '0'
      logic                 left;      // fill goes after the digits
      logic                 upper;     // upper-case hex letters
   } fmt_desc_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CHAR_ZERO + {4'b0, d};
      end else if (upper) begin
         r = CHAR_UPPER_A + {4'b0, d} - 8'd10;
      end else begin
         r = CHAR_LOWER_A + {4'b0, d} - 8'd10;
      end
      return r;
   endfunction

endpackage

// ===== rtl/unsigned_int_text_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// unsigned_int_text_formatter_unit - printf-style unsigned integer formatter
// Renders a 32-bit unsigned value as decimal or hex ASCII text with width,
// precision, zero-pad and left-justify, one character per output beat.
// ----------------------------------------------------------------------------
// A request beat carries the value and its format; the unit answers with the
// formatted text as a run of character beats, rsp_tlast marking the final one.
// An empty text (zero value with precision zero and no width) produces no
// beats at all. Width and precision saturate at MAX_FIELD, so no run exceeds
// MAX_FIELD characters. The front end holds one request at a time: a decimal
// request passes through intake, 32 shift-and-add-3 BCD steps and hand-off,
// a hex request through intake and hand-off; hand-off waits while the job
// queue is full. The emitter then sends one character per cycle while
// rsp_tready allows. A two-entry job queue sits between them, so a request is
// taken while earlier text is still going out. No start-up sweep is needed
// after reset.
module unsigned_int_text_formatter_unit #(
   parameter int MAX_FIELD = 64        // saturation limit for width and precision, 10..64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // value[31:0], field_width[38:32], has_precision[39],
                                    // min_digits[46:40], zero_pad[47], left_justify[48],
                                    // zeros[55:49]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_char[7:0]
   output logic        rsp_tlast    // last_char
);
   import ufmt_pkg::*;

   fmt_desc_type push_desc, pop_desc;
   logic         push, full, pop, empty;

   // front end: intake, BCD conversion, section lengths
   ufmt_front #(
      .MAX_FIELD(MAX_FIELD)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_mode         (req_tuser),
      .req_value        (req_tdata[31:0]),
      .req_field_width  (req_tdata[38:32]),
      .req_has_precision(req_tdata[39]),
      .req_min_digits   (req_tdata[46:40]),
      .req_zero_pad     (req_tdata[47]),
      .req_left_justify (req_tdata[48]),
      .push             (push),
      .push_desc        (push_desc),
      .full             (full)
   );

   // hold finished jobs until the emitter is free
   ufmt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_desc(push_desc),
      .full     (full),
      .pop      (pop),
      .pop_desc (pop_desc),
      .empty    (empty)
   );

   // back end: one character per beat through a registered output stage
   ufmt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_desc (pop_desc),
      .empty    (empty),
      .pop      (pop),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_char (rsp_tdata),
      .rsp_last (rsp_tlast)
   );

endmodule

// ===== rtl/ufmt_front.sv =====
// ----------------------------------------------------------------------------
// ufmt_front - request intake and digit extraction
// Takes one request, converts decimal values to BCD by shift-and-add-3,
// works out the section lengths and hands a job descriptor to the queue.
// ----------------------------------------------------------------------------
module ufmt_front #(
   parameter int MAX_FIELD = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic [31:0]           req_value,
   input  logic [6:0]            req_field_width,
   input  logic                  req_has_precision,
   input  logic [6:0]            req_min_digits,
   input  logic                  req_zero_pad,
   input  logic                  req_left_justify,
   output logic                  push,
   output ufmt_pkg::fmt_desc_type push_desc,
   input  logic                  full
);
   import ufmt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;
   localparam logic [FieldBits-1:0] MaxField = FieldBits'(MAX_FIELD);

   logic [1:0]           state_ff, state_in;
   logic [4:0]           step_ff, step_in;
   logic [31:0]          bin_ff, bin_in;
   digit_vec_type        bcd_ff, bcd_in, bcd_adj;
   logic [DigitCount*4-1:0] bcd_flat;
   logic [FieldBits-1:0] width_ff, prec_ff;
   logic                 has_prec_ff, zero_pad_ff, left_ff, upper_ff;
   logic                 accept;
   logic [DigitBits-1:0] msd, ndig;
   logic                 all_zero;
   logic [FieldBits-1:0] body;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // add 3 to every BCD digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DigitCount; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   // flat view of the adjusted digits for the one-bit shift
   assign bcd_flat = bcd_adj;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in = '0;
               bin_in  = req_value;
               if (req_mode == MODE_DEC) begin
                  bcd_in   = '0;
                  state_in = ST_CONV;
               end else begin
                  bcd_in   = digit_vec_type'({8'h00, req_value});
                  state_in = ST_PUSH;
               end
            end
         end
         ST_CONV: begin
            bcd_in  = {bcd_flat[DigitCount*4-2:0], bin_ff[31]};
            bin_in  = {bin_ff[30:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      if (accept) begin
         width_ff    <= (req_field_width > MaxField) ? MaxField : req_field_width;
         prec_ff     <= !req_has_precision ? '0 :
                        (req_min_digits > MaxField) ? MaxField : req_min_digits;
         has_prec_ff <= req_has_precision;
         zero_pad_ff <= req_zero_pad;
         left_ff     <= req_left_justify;
         upper_ff    <= (req_mode != MODE_LHEX);
      end
   end

   // position of the most significant non-zero digit
   always_comb begin
      msd = '0;
      for (int i = 0; i < DigitCount; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            msd = DigitBits'(i + 1);
         end
      end
   end

   assign all_zero = (msd == '0);
   assign ndig     = all_zero ? (has_prec_ff ? '0 : DigitBits'(1)) : msd;
   assign body     = (prec_ff > {3'b0, ndig}) ? prec_ff : {3'b0, ndig};

   assign push = (state_ff == ST_PUSH) && !full;

   always_comb begin
      push_desc.digits    = bcd_ff;
      push_desc.ndig      = ndig;
      push_desc.lead      = body - {3'b0, ndig};
      push_desc.pad       = (width_ff > body) ? width_ff - body : '0;
      push_desc.fill_zero = zero_pad_ff && !left_ff && !has_prec_ff;
      push_desc.left      = left_ff;
      push_desc.upper     = upper_ff;
   end

endmodule

// ===== rtl/ufmt_queue.sv =====
// ----------------------------------------------------------------------------
// ufmt_queue - two-entry job queue
// Decouples the digit front end from the character emitter.
// ----------------------------------------------------------------------------
module ufmt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ufmt_pkg::fmt_desc_type push_desc,
   output logic                   full,
   input  logic                   pop,
   output ufmt_pkg::fmt_desc_type pop_desc,
   output logic                   empty
);
   import ufmt_pkg::*;

   fmt_desc_type slot_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_desc = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("job pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("job popped from an empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ===== rtl/ufmt_back.sv =====
// ----------------------------------------------------------------------------
// ufmt_back - character emitter
// Walks a job's fill, precision zeros, digits and trailing fill, one
// character per beat, into a registered output stage.
// ----------------------------------------------------------------------------
module ufmt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ufmt_pkg::fmt_desc_type pop_desc,
   input  logic                   empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_char,
   output logic                   rsp_last
);
   import ufmt_pkg::*;

   logic                 busy_ff;
   digit_vec_type        digits_ff;
   logic [DigitBits-1:0] dig_ff;
   logic [FieldBits-1:0] lead_ff, pad_ff;
   logic                 fill_zero_ff, left_ff, upper_ff;
   logic                 out_valid_ff;
   logic [7:0]           out_char_ff;
   logic                 out_last_ff;

   logic                 advance, emit;
   logic [7:0]           total, load_total;
   logic [7:0]           cur_char;
   logic [DigitBits-1:0] dig_idx;

   assign advance    = !out_valid_ff || rsp_ready;
   assign emit       = busy_ff && advance;
   assign pop        = !busy_ff && !empty;
   assign total      = {1'b0, pad_ff} + {1'b0, lead_ff} + {4'b0, dig_ff};
   assign load_total = {1'b0, pop_desc.pad} + {1'b0, pop_desc.lead} + {4'b0, pop_desc.ndig};
   assign dig_idx    = dig_ff - DigitBits'(1);

   always_comb begin
      if (!left_ff && pad_ff != '0) begin
         cur_char = fill_zero_ff ? CHAR_ZERO : CHAR_SPACE;
      end else if (lead_ff != '0) begin
         cur_char = CHAR_ZERO;
      end else if (dig_ff != '0) begin
         cur_char = digit_char(digits_ff[dig_idx], upper_ff);
      end else begin
         cur_char = CHAR_SPACE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= (load_total != 8'd0);
         end else if (emit && total == 8'd1) begin
            busy_ff <= 1'b0;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (pop) begin
         digits_ff    <= pop_desc.digits;
         dig_ff       <= pop_desc.ndig;
         lead_ff      <= pop_desc.lead;
         pad_ff       <= pop_desc.pad;
         fill_zero_ff <= pop_desc.fill_zero;
         left_ff      <= pop_desc.left;
         upper_ff     <= pop_desc.upper;
      end else if (emit) begin
         if (!left_ff && pad_ff != '0) begin
            pad_ff <= pad_ff - FieldBits'(1);
         end else if (lead_ff != '0) begin
            lead_ff <= lead_ff - FieldBits'(1);
         end else if (dig_ff != '0) begin
            dig_ff <= dig_idx;
         end else begin
            pad_ff <= pad_ff - FieldBits'(1);
         end
      end
      if (emit) begin
         out_char_ff <= cur_char;
         out_last_ff <= (total == 8'd1);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_char  = out_char_ff;
   assign rsp_last  = out_last_ff;

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> total != 8'd0) else $error("emitter busy with nothing left");
   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      (emit && total == 8'd1) |=> !busy_ff) else $error("job outlived its last beat");

endmodule
